// ===== rtl/brpc_pkg.sv =====
// Shared types and constants for the block range prime counter.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package brpc_pkg;

    localparam int IDX_W     = 8;
    localparam int PC_W      = 9;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PARTS = 2'd1;

    typedef logic [1:0] div_sel_t;

    localparam div_sel_t SEL_LO  = 2'd0;
    localparam div_sel_t SEL_HI  = 2'd1;
    localparam div_sel_t SEL_MOD = 2'd2;

    typedef struct packed {
        logic     load;
        logic     mul;
        logic     set_empty;
        logic     div_start;
        div_sel_t div_sel;
        logic     take_first;
        logic     take_last;
        logic     cand_init;
        logic     cand_next;
        logic     count_inc;
        logic     trial_three;
        logic     trial_next;
    } brpc_cmd_t;

    typedef struct packed {
        logic div_done;
        logic rem_zero;
        logic idx_out;
        logic cand_le_last;
        logic cand_lt2;
        logic cand_lt4;
        logic sq_le_cand;
        logic cand_odd;
    } brpc_stat_t;

endpackage

`default_nettype wire

// ===== rtl/brpc_divider.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Standalone; used by brpc_datapath for range bounds and trial remainders.
`default_nettype none

module brpc_divider #(
    parameter int NW = 28,
    parameter int DW = 20
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [NW-1:0] dividend,
    input  wire logic [DW-1:0] divisor,
    output logic               done,
    output logic [NW-1:0]      quotient,
    output logic [DW-1:0]      remainder
);

    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] quo_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] dvs_reg;
    logic [CW-1:0] cnt_reg;
    logic          run_reg;
    logic          done_reg;

    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          fits;

    always_comb
    begin
        trial = {rem_reg, quo_reg[NW-1]};
        diff  = trial - {1'b0, dvs_reg};
        fits  = (trial >= {1'b0, dvs_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CW'(NW);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (run_reg)
        begin
            if (fits)
            begin
                rem_reg <= diff[DW-1:0];
                quo_reg <= {quo_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[DW-1:0];
                quo_reg <= {quo_reg[NW-2:0], 1'b0};
            end
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ===== rtl/brpc_datapath.sv =====
// Datapath: configuration registers, range bounds, candidate and trial registers.
// Depends on brpc_pkg and brpc_divider; steered by brpc_ctrl through brpc_cmd_t.
`default_nettype none

module brpc_datapath #(
    parameter int VALUE_WIDTH = 20,
    parameter int MAX_PARTS   = 256,
    parameter int CFG_W       = 20
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [brpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]                cfg_data,
    input  wire logic [brpc_pkg::IDX_W-1:0]      part_index,
    input  wire brpc_pkg::brpc_cmd_t             cmd,
    output brpc_pkg::brpc_stat_t                 stat,
    output logic [VALUE_WIDTH-1:0]               prime_count,
    output logic [VALUE_WIDTH:0]                 range_first,
    output logic [VALUE_WIDTH-1:0]               range_last
);

    localparam int VW  = VALUE_WIDTH;
    localparam int PW  = VW + brpc_pkg::IDX_W;
    localparam int DVW = (VW > brpc_pkg::PC_W) ? VW : brpc_pkg::PC_W;
    localparam int PC_CAP = (1 << brpc_pkg::PC_W) - 1;
    localparam logic [brpc_pkg::PC_W-1:0] PC_MAX =
        brpc_pkg::PC_W'((MAX_PARTS > PC_CAP) ? PC_CAP : MAX_PARTS);

    logic [VW-1:0]               limit_reg;
    logic [brpc_pkg::PC_W-1:0]   pc_reg;
    logic [brpc_pkg::IDX_W-1:0]  idx_reg;
    logic [brpc_pkg::PC_W-1:0]   parts_reg;
    logic [PW-1:0]               prod_reg;
    logic [VW:0]                 first_reg;
    logic [VW-1:0]               last_reg;
    logic [VW:0]                 cand_reg;
    logic [VW-1:0]               trial_reg;
    logic [VW+1:0]               sq_reg;
    logic [VW-1:0]               count_reg;

    logic [PW-1:0]               dvd;
    logic [DVW-1:0]              dvs;
    logic                        div_done;
    logic [PW-1:0]               quo;
    logic [DVW-1:0]              rem;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= '0;
            pc_reg    <= brpc_pkg::PC_W'(1);
        end
        else if (cfg_we)
        begin
            if (cfg_index == brpc_pkg::REG_LIMIT)
            begin
                limit_reg <= cfg_data[VW-1:0];
            end
            else if (cfg_index == brpc_pkg::REG_PARTS)
            begin
                pc_reg <= cfg_data[brpc_pkg::PC_W-1:0];
            end
        end
    end

    always_comb
    begin
        case (cmd.div_sel)
            brpc_pkg::SEL_HI:
            begin
                dvd = prod_reg + PW'(limit_reg);
                dvs = DVW'(parts_reg);
            end
            brpc_pkg::SEL_MOD:
            begin
                dvd = PW'(cand_reg);
                dvs = DVW'(trial_reg);
            end
            default:
            begin
                dvd = prod_reg;
                dvs = DVW'(parts_reg);
            end
        endcase
    end

    brpc_divider #(
        .NW (PW),
        .DW (DVW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (dvd),
        .divisor   (dvs),
        .done      (div_done),
        .quotient  (quo),
        .remainder (rem)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            idx_reg   <= part_index;
            count_reg <= '0;
            if (pc_reg == '0)
            begin
                parts_reg <= brpc_pkg::PC_W'(1);
            end
            else if (pc_reg > PC_MAX)
            begin
                parts_reg <= PC_MAX;
            end
            else
            begin
                parts_reg <= pc_reg;
            end
        end
        if (cmd.mul)
        begin
            prod_reg <= PW'(idx_reg) * PW'(limit_reg);
        end
        if (cmd.set_empty)
        begin
            first_reg <= {1'b0, limit_reg} + (VW+1)'(1);
            last_reg  <= limit_reg;
        end
        if (cmd.take_first)
        begin
            first_reg <= {1'b0, quo[VW-1:0]} + (VW+1)'(1);
        end
        if (cmd.take_last)
        begin
            last_reg <= quo[VW-1:0];
        end
        if (cmd.cand_init)
        begin
            cand_reg <= first_reg;
        end
        else if (cmd.cand_next)
        begin
            cand_reg <= cand_reg + (VW+1)'(1);
        end
        if (cmd.count_inc)
        begin
            count_reg <= count_reg + VW'(1);
        end
        if (cmd.trial_three)
        begin
            trial_reg <= VW'(3);
            sq_reg    <= (VW+2)'(9);
        end
        else if (cmd.trial_next)
        begin
            // (d+2)^2 = d^2 + 4d + 4
            trial_reg <= trial_reg + VW'(2);
            sq_reg    <= sq_reg + {trial_reg, 2'b00} + (VW+2)'(4);
        end
    end

    always_comb
    begin
        stat.div_done     = div_done;
        stat.rem_zero     = (rem == '0);
        stat.idx_out      = ({1'b0, idx_reg} >= parts_reg);
        stat.cand_le_last = (cand_reg <= {1'b0, last_reg});
        stat.cand_lt2     = (cand_reg < (VW+1)'(2));
        stat.cand_lt4     = (cand_reg < (VW+1)'(4));
        stat.sq_le_cand   = (sq_reg <= {1'b0, cand_reg});
        stat.cand_odd     = cand_reg[0];
    end

    assign prime_count = count_reg;
    assign range_first = first_reg;
    assign range_last  = last_reg;

endmodule

`default_nettype wire

// ===== rtl/brpc_ctrl.sv =====
// Controller state machine: sequences range division, candidate walk and trials.
// Depends on brpc_pkg; drives brpc_datapath through brpc_cmd_t.
`default_nettype none

module brpc_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire brpc_pkg::brpc_stat_t stat,
    output brpc_pkg::brpc_cmd_t       cmd,
    output logic                      busy,
    output logic                      done
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL   = 4'd1;
    localparam logic [3:0] S_RANGE = 4'd2;
    localparam logic [3:0] S_DLO   = 4'd3;
    localparam logic [3:0] S_DHI   = 4'd4;
    localparam logic [3:0] S_CINIT = 4'd5;
    localparam logic [3:0] S_CAND  = 4'd6;
    localparam logic [3:0] S_DMOD  = 4'd8;
    localparam logic [3:0] S_SQ    = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        cmd.div_sel = brpc_pkg::SEL_LO;
        state_next = state_reg;
        case (state_reg)
            S_IDLE, S_DONE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MUL;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_RANGE;
            end
            S_RANGE:
            begin
                if (stat.idx_out)
                begin
                    cmd.set_empty = 1'b1;
                    state_next    = S_CINIT;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = brpc_pkg::SEL_LO;
                    state_next    = S_DLO;
                end
            end
            S_DLO:
            begin
                if (stat.div_done)
                begin
                    cmd.take_first = 1'b1;
                    cmd.div_start  = 1'b1;
                    cmd.div_sel    = brpc_pkg::SEL_HI;
                    state_next     = S_DHI;
                end
            end
            S_DHI:
            begin
                cmd.div_sel = brpc_pkg::SEL_HI;
                if (stat.div_done)
                begin
                    cmd.take_last = 1'b1;
                    state_next    = S_CINIT;
                end
            end
            S_CINIT:
            begin
                cmd.cand_init = 1'b1;
                state_next    = S_CAND;
            end
            S_CAND:
            begin
                if (!stat.cand_le_last)
                begin
                    state_next = S_DONE;
                end
                else if (stat.cand_lt2)
                begin
                    cmd.cand_next = 1'b1;
                end
                else if (stat.cand_lt4)
                begin
                    cmd.count_inc = 1'b1;
                    cmd.cand_next = 1'b1;
                end
                else if (!stat.cand_odd)
                begin
                    // An even candidate of four or more has the factor two.
                    cmd.cand_next = 1'b1;
                end
                else
                begin
                    cmd.trial_three = 1'b1;
                    state_next      = S_SQ;
                end
            end
            S_DMOD:
            begin
                cmd.div_sel = brpc_pkg::SEL_MOD;
                if (stat.div_done)
                begin
                    if (stat.rem_zero)
                    begin
                        cmd.cand_next = 1'b1;
                        state_next    = S_CAND;
                    end
                    else
                    begin
                        cmd.trial_next = 1'b1;
                        state_next     = S_SQ;
                    end
                end
            end
            S_SQ:
            begin
                // Once the trial divisor squared exceeds the candidate, it is prime.
                if (stat.sq_le_cand)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = brpc_pkg::SEL_MOD;
                    state_next    = S_DMOD;
                end
                else
                begin
                    cmd.count_inc = 1'b1;
                    cmd.cand_next = 1'b1;
                    state_next    = S_CAND;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE) && (state_reg != S_DONE);
    assign done = (state_reg == S_DONE);

endmodule

`default_nettype wire

// ===== rtl/block_range_prime_counter_unit.sv =====
// Top level of the block range prime counter: controller plus datapath.
// Depends on brpc_pkg, brpc_ctrl, brpc_datapath (and brpc_divider below it).
//
//  channel   signals                                   direction  transfer
//  request   start, busy, part_index                   in         start && !busy
//  result    done, prime_count, range_first, range_last out       done (one cycle)
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data in         cfg_valid && cfg_ready
//
// One request runs to completion before the next is taken. For an index within
// the part count the range bounds take two divisions; then each odd candidate
// of five or more takes one trial division per odd divisor up to its square
// root. All run on the shared bit-serial divider.
// Reset needs no clearing pass. The result strobe cannot be stalled, and a new
// request may be taken in the same cycle as done.
`default_nettype none

module block_range_prime_counter_unit #(
    parameter int VALUE_WIDTH = 20,
    parameter int MAX_PARTS   = 256
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire logic [brpc_pkg::IDX_W-1:0]            part_index,
    output logic                                       done,
    output logic [VALUE_WIDTH-1:0]                     prime_count,
    output logic [VALUE_WIDTH:0]                       range_first,
    output logic [VALUE_WIDTH-1:0]                     range_last,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [brpc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [((VALUE_WIDTH > brpc_pkg::PC_W) ?
                        VALUE_WIDTH : brpc_pkg::PC_W)-1:0] cfg_data
);

    localparam int CFG_W = (VALUE_WIDTH > brpc_pkg::PC_W) ? VALUE_WIDTH : brpc_pkg::PC_W;

    brpc_pkg::brpc_cmd_t  cmd;
    brpc_pkg::brpc_stat_t stat;

    assign cfg_ready = 1'b1;

    brpc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    brpc_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .MAX_PARTS   (MAX_PARTS),
        .CFG_W       (CFG_W)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .part_index  (part_index),
        .cmd         (cmd),
        .stat        (stat),
        .prime_count (prime_count),
        .range_first (range_first),
        .range_last  (range_last)
    );

endmodule

`default_nettype wire

// ===== rtl/brpc_checker.sv =====
// Port-level checker for the block range prime counter, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module brpc_checker #(
    parameter int VALUE_WIDTH = 20
) (
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   start,
    input wire logic                   busy,
    input wire logic                   done,
    input wire logic [VALUE_WIDTH-1:0] prime_count,
    input wire logic [VALUE_WIDTH:0]   range_first,
    input wire logic [VALUE_WIDTH-1:0] range_last
);

    // The result strobe only appears once a request has finished.
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
    else $error("done raised while busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
    else $error("done held longer than one cycle");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy && !start) |=> !done)
    else $error("result without a request");

    // A range never runs backward by more than one, and cannot hold more primes than numbers.
    a_range_sane: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((range_first <= ({1'b0, range_last} + (VALUE_WIDTH+1)'(1)))
              && ((VALUE_WIDTH+1)'(prime_count) + range_first
                  <= {1'b0, range_last} + (VALUE_WIDTH+1)'(1))))
    else $error("result range inconsistent");

endmodule

bind block_range_prime_counter_unit brpc_checker #(
    .VALUE_WIDTH (VALUE_WIDTH)
) u_brpc_checker (.*);

`default_nettype wire

// ===== dv/tb_block_range_prime_counter_unit.sv =====
`timescale 1ns / 1ps
// Testbench for block_range_prime_counter_unit: register writes and part requests,
// with every result checked against a trial-division count kept in the bench.
// Depends on brpc_pkg and the RTL of the block.

module tb_block_range_prime_counter_unit;

    localparam int VW         = 20;
    localparam int MAXP       = 256;
    localparam int CFG_W      = (VW > brpc_pkg::PC_W) ? VW : brpc_pkg::PC_W;
    localparam int SHARE_SPAN = 24;
    localparam int TAIL_WAIT  = 4 * (VW + 10);
    localparam logic [brpc_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef enum logic {OP_COUNT, OP_WRITE} op_kind_t;

    typedef struct {
        op_kind_t                       kind;
        logic [brpc_pkg::IDX_W-1:0]     part;
        logic [brpc_pkg::CFG_IDX_W-1:0] reg_sel;
        logic [CFG_W-1:0]               value;
    } host_op_t;

    typedef struct {
        logic [VW-1:0] primes;
        logic [VW:0]   first;
        logic [VW-1:0] last;
    } share_t;

    logic                           clk         = 1'b0;
    logic                           rst_n       = 1'b0;
    logic                           start       = 1'b0;
    logic [brpc_pkg::IDX_W-1:0]     part_index  = '0;
    logic                           cfg_valid   = 1'b0;
    logic [brpc_pkg::CFG_IDX_W-1:0] cfg_index   = '0;
    logic [CFG_W-1:0]               cfg_data    = '0;
    logic                           busy;
    logic                           done;
    logic                           cfg_ready;
    logic [VW-1:0]                  prime_count;
    logic [VW:0]                    range_first;
    logic [VW-1:0]                  range_last;

    host_op_t                  host_ops[$];
    share_t                    pending_shares[$];
    logic [VW-1:0]             limit_reg      = '0;
    logic [brpc_pkg::PC_W-1:0] parts_reg      = 9'd1;
    bit                        req_fired      = 1'b0;
    bit                        cfg_fired      = 1'b0;
    int                        fault_count    = 0;
    int                        issued         = 0;

    block_range_prime_counter_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .part_index  (part_index),
        .done        (done),
        .prime_count (prime_count),
        .range_first (range_first),
        .range_last  (range_last),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #4 clk = ~clk;

    // Bounds of the requested share and the number of primes in it.
    function automatic share_t count_share(input logic [brpc_pkg::IDX_W-1:0] idx);
        longint unsigned parts;
        longint unsigned lim;
        longint unsigned k;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned n;
        longint unsigned d;
        longint unsigned tally;
        bit              prime;
        share_t          r;
        parts = longint'(parts_reg);
        if (parts == 0)
            parts = 1;
        if (parts > MAXP)
            parts = MAXP;
        lim = longint'(limit_reg);
        k   = longint'(idx);
        if (k >= parts)
        begin
            lo = lim + 1;
            hi = lim;
        end
        else
        begin
            lo = (k * lim) / parts + 1;
            hi = ((k + 1) * lim) / parts;
        end
        tally = 0;
        for (n = lo; n <= hi; n++)
        begin
            prime = (n >= 2);
            for (d = 2; prime && d * d <= n; d++)
                if (n % d == 0)
                    prime = 1'b0;
            if (prime)
                tally++;
        end
        r.primes = VW'(tally);
        r.first  = (VW+1)'(lo);
        r.last   = VW'(hi);
        return r;
    endfunction

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want !== got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fault_count++;
        end
    endtask

    // Monitor: checks results, then records what was accepted at this edge.
    always @(posedge clk)
    begin
        share_t want;
        req_fired = rst_n && start && !busy;
        cfg_fired = rst_n && cfg_valid && cfg_ready;
        if (rst_n && done)
        begin
            if (pending_shares.size() == 0)
            begin
                $error("result with no request outstanding: prime_count %0d", prime_count);
                fault_count++;
            end
            else
            begin
                want = pending_shares.pop_front();
                check_field("prime_count", want.primes, prime_count);
                check_field("range_first", want.first, range_first);
                check_field("range_last", want.last, range_last);
            end
        end
        if (req_fired)
            pending_shares.push_back(count_share(part_index));
        if (cfg_fired)
        begin
            case (cfg_index)
                brpc_pkg::REG_LIMIT: limit_reg = cfg_data[VW-1:0];
                brpc_pkg::REG_PARTS: parts_reg = cfg_data[brpc_pkg::PC_W-1:0];
                default: ;
            endcase
        end
    end

    // Driver: a register write goes out only once every result is back.
    always @(negedge clk)
    begin
        host_op_t op;
        bit       hold;
        bit       rest;
        if (rst_n)
        begin
            hold = (start && !req_fired) || (cfg_valid && !cfg_fired);
            if (!hold)
            begin
                rest = (issued < 40 || issued >= 70) && ($urandom_range(99) < 38);
                if (!rest && host_ops.size() > 0 &&
                    (host_ops[0].kind == OP_COUNT || (pending_shares.size() == 0 && !busy)))
                begin
                    op = host_ops.pop_front();
                    issued++;
                    start     <= (op.kind == OP_COUNT);
                    cfg_valid <= (op.kind == OP_WRITE);
                    if (op.kind == OP_COUNT)
                        part_index <= op.part;
                    else
                    begin
                        cfg_index <= op.reg_sel;
                        cfg_data  <= op.value;
                    end
                end
                else
                begin
                    start     <= 1'b0;
                    cfg_valid <= 1'b0;
                end
            end
        end
    end

    task automatic add_count(input logic [brpc_pkg::IDX_W-1:0] idx);
        host_op_t op;
        op.kind    = OP_COUNT;
        op.part    = idx;
        op.reg_sel = brpc_pkg::REG_LIMIT;
        op.value   = '0;
        host_ops.push_back(op);
    endtask

    task automatic add_write(input logic [brpc_pkg::CFG_IDX_W-1:0] sel,
                             input logic [CFG_W-1:0] value);
        host_op_t op;
        op.kind    = OP_WRITE;
        op.part    = '0;
        op.reg_sel = sel;
        op.value   = value;
        host_ops.push_back(op);
    endtask

    initial
    begin
        int                        rand_count;
        int                        eff;
        int                        phase_len;
        bit                        wide;
        logic [VW-1:0]             lim;
        logic [brpc_pkg::PC_W-1:0] pc;
        logic [CFG_W-1:0]          pdata;

        // Reset values: an empty share, and an index past the only part.
        add_count(8'd0);
        add_count(8'd255);
        // A part count of zero behaves as one.
        add_write(brpc_pkg::REG_LIMIT, 20'd50);
        add_write(brpc_pkg::REG_PARTS, 20'd0);
        add_count(8'd0);
        add_count(8'd1);
        add_count(8'd255);
        add_write(brpc_pkg::REG_LIMIT, 20'd100);
        add_write(brpc_pkg::REG_PARTS, 20'd7);
        add_count(8'd0);
        add_count(8'd3);
        add_count(8'd6);
        add_count(8'd7);
        // One number per share: 1 never counts, 2 and 3 do, 4, 9 and 25 do not.
        add_write(brpc_pkg::REG_LIMIT, 20'd25);
        add_write(brpc_pkg::REG_PARTS, 20'd25);
        add_write(REG_SPARE, 20'hFFFFF);
        add_count(8'd0);
        add_count(8'd1);
        add_count(8'd2);
        add_count(8'd3);
        add_count(8'd8);
        add_count(8'd24);
        // Shares holding the squares of 11 and 13.
        add_write(brpc_pkg::REG_LIMIT, 20'd1024);
        add_write(brpc_pkg::REG_PARTS, 20'd256);
        add_count(8'd30);
        add_count(8'd42);
        // A part count above the maximum saturates.
        add_write(brpc_pkg::REG_PARTS, 20'd300);
        add_write(brpc_pkg::REG_LIMIT, 20'd768);
        add_count(8'd0);
        add_count(8'd255);
        add_write(brpc_pkg::REG_LIMIT, 20'hFFFFF);
        add_write(brpc_pkg::REG_PARTS, 20'd1);
        add_count(8'd1);
        add_count(8'd255);

        // Random phases keep shares short so that the count stays cheap, except for
        // wide limits, which are paired only with indexes past the last part.
        rand_count = 0;
        while (rand_count < 76)
        begin
            if ($urandom_range(9) < 8)
                pc = brpc_pkg::PC_W'($urandom_range(1, MAXP));
            else if ($urandom_range(1))
                pc = '0;
            else
                pc = brpc_pkg::PC_W'($urandom_range(MAXP + 1, (1 << brpc_pkg::PC_W) - 1));
            eff = (pc == 0) ? 1 : ((pc > MAXP) ? MAXP : int'(pc));
            wide = (eff < MAXP) && ($urandom_range(99) < 12);
            if (wide)
                lim = $urandom_range(1) ? 20'hFFFFF : VW'($urandom);
            else
                lim = VW'($urandom_range(0, eff * SHARE_SPAN));
            pdata = CFG_W'($urandom);
            if ($urandom_range(1))
                pdata[CFG_W-1:brpc_pkg::PC_W] = '0;
            pdata[brpc_pkg::PC_W-1:0] = pc;
            if ($urandom_range(1))
            begin
                add_write(brpc_pkg::REG_LIMIT, CFG_W'(lim));
                add_write(brpc_pkg::REG_PARTS, pdata);
            end
            else
            begin
                add_write(brpc_pkg::REG_PARTS, pdata);
                add_write(brpc_pkg::REG_LIMIT, CFG_W'(lim));
            end
            if ($urandom_range(9) == 0)
                add_write(REG_SPARE, CFG_W'($urandom));
            phase_len = $urandom_range(3, 10);
            repeat (phase_len)
            begin
                if (wide)
                    add_count(brpc_pkg::IDX_W'($urandom_range(eff, 255)));
                else if ($urandom_range(9) < 8)
                    add_count(brpc_pkg::IDX_W'($urandom_range(0, eff - 1)));
                else
                    add_count(brpc_pkg::IDX_W'($urandom_range(0, 255)));
                rand_count++;
            end
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (host_ops.size() > 0 || start || cfg_valid || pending_shares.size() > 0)
            @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);

        if (fault_count == 0 && pending_shares.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #100_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
